/* rtl/core/irn_pkg.sv */
// Shared types, constants and pair tables for the Roman numeral encoder.
// No dependencies; imported by every module of the core.
package irn_pkg;

    localparam int VALUE_W   = 16;
    localparam int REST_W    = 12;
    localparam int CHAR_W    = 8;
    localparam int PAIR_N    = 13;
    localparam int PAIR_IDX_W = $clog2(PAIR_N);

    localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(3999);
    localparam logic [CHAR_W-1:0]  NO_CHAR   = '0;

    typedef logic [REST_W-1:0]     t_rest;
    typedef logic [CHAR_W-1:0]     t_char;
    typedef logic [PAIR_IDX_W-1:0] t_pair_idx;

    // One classified word between the front and the back end.
    typedef struct packed {
        logic  err;
        t_rest value;
    } t_job;

    localparam t_rest PAIR_WEIGHT [PAIR_N] = '{
        REST_W'(1000), REST_W'(900), REST_W'(500), REST_W'(400), REST_W'(100),
        REST_W'(90),   REST_W'(50),  REST_W'(40),  REST_W'(10),  REST_W'(9),
        REST_W'(5),    REST_W'(4),   REST_W'(1)
    };

    localparam t_char PAIR_FIRST [PAIR_N] = '{
        "M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"
    };

    // NO_CHAR marks a single-character pair.
    localparam t_char PAIR_SECOND [PAIR_N] = '{
        NO_CHAR, "M", NO_CHAR, "D", NO_CHAR, "C", NO_CHAR, "L", NO_CHAR, "X",
        NO_CHAR, "V", NO_CHAR
    };

    // Largest pair whose weight fits in the remainder (remainder is non-zero).
    function automatic t_pair_idx pick_pair(input t_rest rest);
        t_pair_idx idx;
        idx = t_pair_idx'(PAIR_N - 1);
        for (int i = PAIR_N - 1; i >= 0; i--) begin
            if (rest >= PAIR_WEIGHT[i]) begin
                idx = t_pair_idx'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/core/irn_front.sv */
// Front end: takes command words, range-checks them and holds one classified job.
// Depends on irn_pkg.
module irn_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [15:0]   i_value,
    output logic          o_push,
    output irn_pkg::t_job o_job,
    input  logic          i_q_full
);
    import irn_pkg::*;

    logic r_hold;
    t_job r_job;
    logic accept;
    logic out_of_range;

    assign o_push       = r_hold && !i_q_full;
    assign busy         = r_hold && i_q_full;
    assign accept       = start && !busy;
    assign out_of_range = (i_value == '0) || (i_value > MAX_VALUE);
    assign o_job        = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
        end else if (accept) begin
            r_hold <= 1'b1;
        end else if (o_push) begin
            r_hold <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job.err   <= out_of_range;
            r_job.value <= i_value[REST_W-1:0];
        end
    end

endmodule

/* rtl/core/irn_queue.sv */
// Two-entry job queue between the front and the back end.
// Depends on irn_pkg.
module irn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  irn_pkg::t_job i_job,
    input  logic          i_pop,
    output irn_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);
    import irn_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* rtl/core/irn_back.sv */
// Back end: greedy encoder, one numeral character per cycle on a strobe while a job is active.
// Depends on irn_pkg.
module irn_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  irn_pkg::t_job i_job,
    input  logic          i_q_empty,
    output logic          o_pop,
    output logic          o_strobe,
    output logic [7:0]    o_symbol_char,
    output logic          o_last,
    output logic          o_range_error
);
    import irn_pkg::*;

    logic      r_active;
    logic      r_pend;
    t_char     r_pend_char;
    t_rest     r_rest;
    logic      r_strobe;
    t_char     r_char;
    logic      r_last;
    logic      r_err;

    t_pair_idx pair;
    t_rest     rest_sub;

    assign o_pop    = !r_active && !i_q_empty;
    assign pair     = pick_pair(r_rest);
    assign rest_sub = r_rest - PAIR_WEIGHT[pair];

    assign o_strobe      = r_strobe;
    assign o_symbol_char = r_char;
    assign o_last        = r_last;
    assign o_range_error = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            if (!r_active) begin
                r_strobe <= o_pop && i_job.err;
                if (o_pop) begin
                    if (i_job.err) begin
                        // Out of range: one error word, nothing to encode
                        r_char   <= NO_CHAR;
                        r_last   <= 1'b1;
                        r_err    <= 1'b1;
                    end else begin
                        r_active <= 1'b1;
                        r_rest   <= i_job.value;
                    end
                end
            end else if (r_pend) begin
                // Second half of a subtractive pair; remainder already reduced
                r_strobe <= 1'b1;
                r_char   <= r_pend_char;
                r_last   <= (r_rest == '0);
                r_err    <= 1'b0;
                r_pend   <= 1'b0;
                r_active <= (r_rest != '0);
            end else begin
                r_strobe <= 1'b1;
                r_char   <= PAIR_FIRST[pair];
                r_err    <= 1'b0;
                r_rest   <= rest_sub;
                if (PAIR_SECOND[pair] != NO_CHAR) begin
                    r_pend      <= 1'b1;
                    r_pend_char <= PAIR_SECOND[pair];
                    r_last      <= 1'b0;
                end else begin
                    r_last   <= (rest_sub == '0);
                    r_active <= (rest_sub != '0);
                end
            end
        end
    end

endmodule

/* rtl/core/integer_to_roman_numeral_core.sv */
// Integer to Roman numeral encoder: top level joining front end, queue and back end.
// Depends on irn_pkg, irn_front, irn_queue and irn_back.
//
// Issue a value on i_value with start while busy is low. Each value yields a run of
// ASCII numeral characters, one per o_strobe pulse, with o_last on the final one;
// 0 or anything above 3999 yields a single word with o_range_error and o_last set
// and a zero character. The receiver cannot stall: every strobe must be taken in
// its cycle. The back end's encoder emits one character per cycle while a job is
// active and loads each job from the queue before its first character, while an
// error word is emitted in the cycle after it is popped; a two-entry queue and one
// front-end register let up to three further values be issued while a run is in
// progress, after which busy holds off start until the encoder frees a slot.
module integer_to_roman_numeral_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_value,
    output logic        o_strobe,
    output logic [7:0]  o_symbol_char,
    output logic        o_last,
    output logic        o_range_error
);
    import irn_pkg::*;

    logic push;
    t_job front_job;
    t_job head_job;
    logic q_full;
    logic q_empty;
    logic pop;

    irn_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_value  (i_value),
        .o_push   (push),
        .o_job    (front_job),
        .i_q_full (q_full)
    );

    irn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    irn_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_symbol_char (o_symbol_char),
        .o_last        (o_last),
        .o_range_error (o_range_error)
    );

endmodule
